### src/amb_pkg.sv
// Package: types, register codes and constants for the meter ballistics block.
package amb_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFG_AW   = 3;

  localparam logic signed [15:0] LVL_NEG_INF = 16'sh8000;

  localparam logic [15:0]        RST_DECAY_RATE = 16'd6024;
  localparam logic [15:0]        RST_PEAK_HOLD  = 16'd20000;
  localparam logic [15:0]        RST_INPUT_HOLD = 16'd1000;
  localparam logic [15:0]        RST_INT_GAIN   = 16'd216;
  localparam logic signed [15:0] RST_MIN_LEVEL  = -16'sd15360;

  // Rounded division by 1000: (n + 500) / 8, then times ceil(2^36 / 125), then >> 36.
  localparam logic [31:0] DIV_ROUND     = 32'd500;
  localparam int          DIV_PRE_SHIFT = 3;
  localparam int          DIV_N_W       = 32 - DIV_PRE_SHIFT;
  localparam logic [29:0] DIV_RECIP     = 30'd549755814;
  localparam int          DIV_SHIFT     = 36;
  localparam int          DIV_PROD_W    = DIV_N_W + 30;
  localparam int          DECAY_W       = DIV_PROD_W - DIV_SHIFT;

  localparam logic [49:0] MAG_RND_HALF = 50'd32768;
  localparam int          MAG_SHIFT    = 16;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PEAK_DECAY_RATE = 3'd0,
    CFG_PEAK_HOLD_TIME  = 3'd1,
    CFG_INPUT_HOLD_TIME = 3'd2,
    CFG_INT_GAIN        = 3'd3,
    CFG_MIN_LEVEL       = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WB
  } amb_state_e;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [15:0] magnitude;
    logic signed [15:0] peak;
    logic signed [15:0] input_peak;
    logic [31:0]        now_ms;
    logic [15:0]        elapsed_ms;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         channel_out;
    logic signed [15:0] shown_peak;
    logic signed [15:0] held_peak;
    logic signed [15:0] held_input_peak;
    logic signed [15:0] shown_magnitude;
  } out_req_t;

  typedef struct packed {
    logic signed [15:0] peak;
    logic signed [15:0] peak_hold;
    logic [31:0]        peak_stamp;
    logic signed [15:0] input_hold;
    logic [31:0]        input_stamp;
    logic signed [15:0] magnitude;
  } chan_state_t;

  localparam chan_state_t STATE_RESET = '{
    peak:        LVL_NEG_INF,
    peak_hold:   LVL_NEG_INF,
    peak_stamp:  32'd0,
    input_hold:  LVL_NEG_INF,
    input_stamp: 32'd0,
    magnitude:   LVL_NEG_INF
  };

endpackage

### src/audio_meter_ballistics_top.sv
// Top level: per-channel peak meter ballistics with peak hold and VU integration.
//
// Usage: each request on the input channel (in_valid_i / in_stall_o, payload
// in_req_i) is one meter update for one channel. The block answers every
// request with exactly one result on the output channel (out_valid_o /
// out_stall_i, payload out_req_o), in request order.
// Per-channel state sits in one synchronous memory word per channel. A request
// is read at acceptance, goes through two registered multiply steps and is
// written back and loaded into the output register together.
// The block takes no new request until the previous one has passed the read,
// multiply, multiply and write-back sequence of the shared state memory; a
// stalled output register holds that request in write-back.
// Registers are written through cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; the user must write them only while no request is in flight,
// which the block itself does not enforce; unknown indexes are ignored.
// Reset: all channels read as minus infinity with zero hold stamps (per-entry
// valid bits), registers take their defaults, the block is ready at once.
// A stalled result holds in the output register; the next request is accepted
// and processed but waits in write-back until the register frees.
module audio_meter_ballistics_top import amb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_req_t          out_req_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  amb_state_e state_q, state_d;

  logic [15:0]        rate_q, phold_q, ihold_q, gain_q;
  logic signed [15:0] minl_q;

  chan_state_t mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  chan_state_t rd_q;
  logic        rd_vld_q;
  chan_state_t cur_st;
  chan_state_t wr_d;

  in_req_t  in_q;
  out_req_t out_q;
  logic     out_valid_q;

  logic [31:0]            dprod_q;
  logic [DIV_PROD_W-1:0]  div_q;
  logic [DECAY_W-1:0]     decay_q;
  logic [32:0]            m1_q;
  logic [48:0]            p_q;
  logic                   neg_q;

  logic                   accept;
  logic                   out_free;
  logic                   advance;
  logic                   chan_ok;
  logic [DIV_N_W-1:0]     div_n;
  logic signed [16:0]     diff;
  logic [16:0]            mabs;
  logic signed [24:0]     pk_x;
  logic signed [24:0]     pk_in;
  logic [33:0]            mag_a;
  logic signed [35:0]     mag_step;
  logic signed [35:0]     mag_x;
  logic signed [35:0]     minl_x;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign chan_ok     = 32'(in_q.channel) < CHANNELS;
  assign cur_st      = rd_vld_q ? rd_q : STATE_RESET;

  function automatic logic hold_take(logic signed [15:0] cur, logic signed [15:0] hold,
                                     logic [31:0] now, logic [31:0] stamp,
                                     logic [15:0] hold_ms);
    logic [31:0] age;
    age = now - stamp;
    return (cur >= hold) || (age > {16'd0, hold_ms});
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RST_DECAY_RATE;
      phold_q <= RST_PEAK_HOLD;
      ihold_q <= RST_INPUT_HOLD;
      gain_q  <= RST_INT_GAIN;
      minl_q  <= RST_MIN_LEVEL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PEAK_DECAY_RATE: rate_q  <= cfg_data_i;
        CFG_PEAK_HOLD_TIME:  phold_q <= cfg_data_i;
        CFG_INPUT_HOLD_TIME: ihold_q <= cfg_data_i;
        CFG_INT_GAIN:        gain_q  <= cfg_data_i;
        CFG_MIN_LEVEL:       minl_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    advance    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_WB;
      ST_WB: begin
        if (out_free) begin
          advance = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Request capture, state read and first decay product.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q    <= in_req_i;
      rd_q    <= mem_q[in_req_i.channel[CH_AW-1:0]];
      dprod_q <= rate_q * in_req_i.elapsed_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (accept) rd_vld_q <= vld_q[in_req_i.channel[CH_AW-1:0]];
      if (advance && chan_ok) vld_q[in_q.channel[CH_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && chan_ok) mem_q[in_q.channel[CH_AW-1:0]] <= wr_d;
  end

  // First multiply step.
  always_comb begin
    div_n = DIV_N_W'((dprod_q + DIV_ROUND) >> DIV_PRE_SHIFT);
    diff  = 17'(in_q.magnitude) - 17'(cur_st.magnitude);
    mabs  = (diff < 0) ? 17'(-diff) : 17'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      div_q <= div_n * DIV_RECIP;
      m1_q  <= mabs * in_q.elapsed_ms;
      neg_q <= diff < 0;
    end
  end

  // Second multiply step.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      decay_q <= div_q[DIV_PROD_W-1:DIV_SHIFT];
      p_q     <= m1_q * gain_q;
    end
  end

  // Write-back values.
  always_comb begin
    wr_d  = cur_st;
    pk_in = 25'(in_q.peak);
    pk_x  = 25'(cur_st.peak) - $signed({2'b00, decay_q});
    if (in_q.peak >= cur_st.peak) begin
      wr_d.peak = in_q.peak;
    end else if (pk_x < pk_in) begin
      wr_d.peak = in_q.peak;
    end else if (pk_x > 0) begin
      wr_d.peak = '0;
    end else begin
      wr_d.peak = pk_x[15:0];
    end

    if (hold_take(in_q.peak, cur_st.peak_hold, in_q.now_ms, cur_st.peak_stamp, phold_q)) begin
      wr_d.peak_hold  = in_q.peak;
      wr_d.peak_stamp = in_q.now_ms;
    end
    if (hold_take(in_q.input_peak, cur_st.input_hold, in_q.now_ms, cur_st.input_stamp,
                  ihold_q)) begin
      wr_d.input_hold  = in_q.input_peak;
      wr_d.input_stamp = in_q.now_ms;
    end

    mag_a    = 34'(({1'b0, p_q} + MAG_RND_HALF) >> MAG_SHIFT);
    mag_step = $signed({2'b00, mag_a});
    mag_x    = neg_q ? (36'(cur_st.magnitude) - mag_step)
                     : (36'(cur_st.magnitude) + mag_step);
    minl_x   = 36'(minl_q);
    if (cur_st.magnitude == LVL_NEG_INF) begin
      wr_d.magnitude = in_q.magnitude;
    end else if (in_q.magnitude == LVL_NEG_INF) begin
      if (in_q.elapsed_ms != '0 && gain_q != '0) wr_d.magnitude = minl_q;
    end else if (mag_x < minl_x) begin
      wr_d.magnitude = minl_q;
    end else if (mag_x > 0) begin
      wr_d.magnitude = '0;
    end else begin
      wr_d.magnitude = mag_x[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.channel_out <= in_q.channel;
      if (chan_ok) begin
        out_q.shown_peak      <= wr_d.peak;
        out_q.held_peak       <= wr_d.peak_hold;
        out_q.held_input_peak <= wr_d.input_hold;
        out_q.shown_magnitude <= wr_d.magnitude;
      end else begin
        out_q.shown_peak      <= LVL_NEG_INF;
        out_q.held_peak       <= LVL_NEG_INF;
        out_q.held_input_peak <= LVL_NEG_INF;
        out_q.shown_magnitude <= LVL_NEG_INF;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

### src/amb_checker.sv
// Port checker for the meter ballistics block and its bind to the top level.
module amb_checker import amb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input out_req_t          out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous request in flight");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no request in flight");

  a_drop_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result withdrawn without being taken");

endmodule

bind audio_meter_ballistics_top amb_checker u_amb_checker (.*);

### sim/audio_meter_ballistics_top_test.sv
// Self-checking testbench for audio_meter_ballistics_top: directed and random meter updates.
module audio_meter_ballistics_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import amb_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned PHASE_ITEMS     = 320;

  class meter_ledger;
    logic [15:0]        decay_rate;
    logic [15:0]        peak_hold_ms;
    logic [15:0]        input_hold_ms;
    logic [15:0]        gain;
    logic signed [15:0] floor_level;
    chan_state_t        chan [CHANNELS];
    out_req_t           due_readings [$];
    int unsigned        errors;
    int unsigned        noted;
    int unsigned        checked;

    function new();
      decay_rate    = RST_DECAY_RATE;
      peak_hold_ms  = RST_PEAK_HOLD;
      input_hold_ms = RST_INPUT_HOLD;
      gain          = RST_INT_GAIN;
      floor_level   = RST_MIN_LEVEL;
      foreach (chan[i]) chan[i] = STATE_RESET;
      errors  = 0;
      noted   = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] value);
      case (idx)
        CFG_PEAK_DECAY_RATE: decay_rate    = value;
        CFG_PEAK_HOLD_TIME:  peak_hold_ms  = value;
        CFG_INPUT_HOLD_TIME: input_hold_ms = value;
        CFG_INT_GAIN:        gain          = value;
        CFG_MIN_LEVEL:       floor_level   = value;
        default: ;
      endcase
    endfunction

    function void follow_hold(inout logic signed [15:0] held, inout logic [31:0] stamp,
                              input logic signed [15:0] level, input logic [31:0] now,
                              input logic [15:0] span);
      logic [31:0] age;
      age = now - stamp;
      if (level >= held || age > {16'd0, span}) begin
        held  = level;
        stamp = now;
      end
    endfunction

    function void note_update(in_req_t r);
      chan_state_t     s;
      out_req_t        res;
      int              pk;
      int              mag;
      int              cur;
      longint          decay;
      longint          x;
      longint          diff;
      longint          attack;
      longint unsigned diff_abs;
      longint unsigned prod;
      noted++;
      res.channel_out = r.channel;
      if (int'(r.channel) >= CHANNELS) begin
        res.shown_peak      = LVL_NEG_INF;
        res.held_peak       = LVL_NEG_INF;
        res.held_input_peak = LVL_NEG_INF;
        res.shown_magnitude = LVL_NEG_INF;
        due_readings.push_back(res);
        return;
      end
      s  = chan[r.channel];
      pk = $signed(r.peak);
      if (pk >= int'($signed(s.peak))) begin
        s.peak = r.peak;
      end else begin
        decay = (longint'(decay_rate) * longint'(r.elapsed_ms) + 500) / 1000;
        x = longint'($signed(s.peak)) - decay;
        if (x < pk) x = pk;
        else if (x > 0) x = 0;
        s.peak = 16'(x);
      end
      follow_hold(s.peak_hold, s.peak_stamp, r.peak, r.now_ms, peak_hold_ms);
      follow_hold(s.input_hold, s.input_stamp, r.input_peak, r.now_ms, input_hold_ms);
      mag = $signed(r.magnitude);
      cur = $signed(s.magnitude);
      if (cur == int'(LVL_NEG_INF)) begin
        s.magnitude = r.magnitude;
      end else if (mag == int'(LVL_NEG_INF)) begin
        if (r.elapsed_ms != 0 && gain != 0) s.magnitude = floor_level;
      end else begin
        diff     = mag - cur;
        diff_abs = (diff < 0) ? -diff : diff;
        prod     = diff_abs * r.elapsed_ms * gain;
        attack   = (prod + 32768) >> 16;
        x = cur + ((diff < 0) ? -attack : attack);
        if (x < floor_level) x = floor_level;
        else if (x > 0) x = 0;
        s.magnitude = 16'(x);
      end
      chan[r.channel] = s;
      res.shown_peak      = s.peak;
      res.held_peak       = s.peak_hold;
      res.held_input_peak = s.input_hold;
      res.shown_magnitude = s.magnitude;
      due_readings.push_back(res);
    endfunction

    function void compare_field(string what, int ch, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: channel %0d %s expected %0d, got %0d", $time, ch, what, want, got);
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (due_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result for channel %0d", $time, got.channel_out);
        return;
      end
      want = due_readings.pop_front();
      checked++;
      compare_field("channel_out", want.channel_out, want.channel_out, got.channel_out);
      compare_field("shown_peak", want.channel_out, $signed(want.shown_peak),
                    $signed(got.shown_peak));
      compare_field("held_peak", want.channel_out, $signed(want.held_peak),
                    $signed(got.held_peak));
      compare_field("held_input_peak", want.channel_out, $signed(want.held_input_peak),
                    $signed(got.held_input_peak));
      compare_field("shown_magnitude", want.channel_out, $signed(want.shown_magnitude),
                    $signed(got.shown_magnitude));
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_req_t          out_req_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_AW-1:0] cfg_index_i = CFG_PEAK_DECAY_RATE;
  logic [15:0]       cfg_data_i  = '0;

  meter_ledger ledger       = new();
  int unsigned quiet_cycles = 0;
  int unsigned reg_writes   = 0;
  bit          hold_off_req = 1'b0;
  bit          quiet_tail   = 1'b0;
  logic [31:0] clock_ms     = 32'hFFFF_0000;

  audio_meter_ballistics_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) ledger.note_update(in_req_i);
    if (out_valid_o && !out_stall_i) ledger.check_result(out_req_o);
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(negedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("audio_meter_ballistics_top regression: fail");
    $finish;
  end

  initial begin : receiver
    int unsigned span;
    bit          stall_bursts;
    stall_bursts = 1'b1;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) stall_bursts = !stall_bursts;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet_tail && stall_bursts && $urandom_range(0, 5) == 0) begin
        span = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic in_req_t meter_req(int ch, int mag, int pk, int ipk,
                                        logic [31:0] now, int el);
    in_req_t r;
    r.channel    = 3'(ch);
    r.magnitude  = 16'(mag);
    r.peak       = 16'(pk);
    r.input_peak = 16'(ipk);
    r.now_ms     = now;
    r.elapsed_ms = 16'(el);
    return r;
  endfunction

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(0, 19))
      0:       return LVL_NEG_INF;
      1:       return 16'sd0;
      2:       return 16'($urandom_range(1, 32767));
      3:       return 16'(-int'($urandom_range(20000, 32767)));
      default: return 16'(-int'($urandom_range(0, 18000)));
    endcase
  endfunction

  task automatic send_update(in_req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_sender(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic await_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ledger.due_readings.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.write_reg(idx, value);
    reg_writes++;
  endtask

  task automatic program_phase(int unsigned phase);
    case (phase)
      1: begin
        write_reg(CFG_PEAK_DECAY_RATE, 16'd0);
        write_reg(CFG_PEAK_HOLD_TIME, 16'd0);
        write_reg(CFG_INPUT_HOLD_TIME, 16'd0);
        write_reg(CFG_INT_GAIN, 16'd0);
        write_reg(CFG_MIN_LEVEL, LVL_NEG_INF);
      end
      2: begin
        write_reg(CFG_PEAK_DECAY_RATE, 16'hFFFF);
        write_reg(CFG_PEAK_HOLD_TIME, 16'hFFFF);
        write_reg(CFG_INPUT_HOLD_TIME, 16'hFFFF);
        write_reg(CFG_INT_GAIN, 16'hFFFF);
        write_reg(CFG_MIN_LEVEL, 16'sd0);
      end
      3: begin
        write_reg(CFG_PEAK_DECAY_RATE, 16'($urandom));
        write_reg(CFG_PEAK_HOLD_TIME, 16'($urandom_range(0, 2000)));
        write_reg(CFG_INPUT_HOLD_TIME, 16'($urandom_range(0, 2000)));
        write_reg(CFG_INT_GAIN, 16'($urandom));
        write_reg(CFG_MIN_LEVEL, 16'(-int'($urandom_range(0, 32767))));
      end
      4: begin
        write_reg(CFG_PEAK_DECAY_RATE, 16'($urandom_range(0, 20000)));
        write_reg(CFG_PEAK_HOLD_TIME, 16'($urandom_range(0, 300)));
        write_reg(CFG_INPUT_HOLD_TIME, 16'($urandom_range(0, 300)));
        write_reg(CFG_INT_GAIN, 16'($urandom));
        write_reg(CFG_MIN_LEVEL, 16'($urandom_range(1, 32767)));
      end
      5: begin
        write_reg(CFG_PEAK_DECAY_RATE, RST_DECAY_RATE);
        write_reg(CFG_PEAK_HOLD_TIME, RST_PEAK_HOLD);
        write_reg(CFG_INPUT_HOLD_TIME, RST_INPUT_HOLD);
        write_reg(CFG_INT_GAIN, RST_INT_GAIN);
        write_reg(CFG_MIN_LEVEL, RST_MIN_LEVEL);
      end
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned count, bit steady);
    in_req_t r;
    bit      gaps_on;
    gaps_on = 1'b1;
    repeat (count) begin
      r.channel    = 3'($urandom_range(0, CHANNELS - 1));
      r.magnitude  = pick_level();
      r.peak       = pick_level();
      r.input_peak = pick_level();
      case ($urandom_range(0, 19))
        0:       r.elapsed_ms = 16'($urandom);
        1:       r.elapsed_ms = 16'd0;
        default: r.elapsed_ms = 16'($urandom_range(1, 120));
      endcase
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + r.elapsed_ms;
      r.now_ms = clock_ms;
      send_update(r);
      if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
      if (!steady && !quiet_tail && gaps_on && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 4));
    end
  endtask

  initial begin : stimulus
    int unsigned failures;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_update(meter_req(0, LVL_NEG_INF, LVL_NEG_INF, LVL_NEG_INF, 32'd0, 0));
    send_update(meter_req(0, -32767, -32767, -32767, 32'd0, 0));
    send_update(meter_req(0, 0, 0, 0, 32'd5, 65535));
    send_update(meter_req(0, LVL_NEG_INF, LVL_NEG_INF, LVL_NEG_INF, 32'd10, 100));
    send_update(meter_req(0, LVL_NEG_INF, -20000, LVL_NEG_INF, 32'd20, 0));
    send_update(meter_req(1, 32767, 32767, 32767, 32'hFFFF_FFFF, 0));
    send_update(meter_req(1, 256, 256, 256, 32'hFFFF_FFFF, 1000));
    send_update(meter_req(2, -15360, -6000, -3000, 32'hFFFF_FFF0, 10));
    send_update(meter_req(2, -15360, -9000, -9000, 32'h0000_03D8, 10));
    send_update(meter_req(2, -15360, -9000, -9000, 32'h0000_03D9, 10));
    send_update(meter_req(2, -15000, -30000, -30000, 32'h0000_0400, 65535));
    send_update(meter_req(7, -100, -100, -100, 32'h8000_0000, 1));
    send_update(meter_req(7, -15361, -200, -200, 32'h8000_03E8, 1000));
    send_update(meter_req(7, -15360, -300, -300, 32'h8000_07D0, 500));
    send_update(meter_req(3, -256, -256, -256, 32'h7FFF_FFFF, 0));
    send_update(meter_req(3, -255, -255, -255, 32'h8000_0000, 1));
    send_update(meter_req(3, 0, 0, 0, 32'h8000_012F, 303));

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      await_idle();
      program_phase(phase);
      quiet_tail = (phase == PHASES - 1);
      if (phase == 2) begin
        run_random(PHASE_ITEMS / 2, 1'b0);
        hold_off_req = 1'b1;
        run_random(30, 1'b1);
        run_random(PHASE_ITEMS / 2, 1'b0);
      end else if (phase == 3) begin
        run_random(PHASE_ITEMS / 2, 1'b0);
        await_idle();
        run_random(PHASE_ITEMS / 2, 1'b0);
      end else begin
        run_random(PHASE_ITEMS, 1'b0);
      end
    end

    await_idle();
    repeat (8) @(posedge clk_i);
    failures = ledger.errors + ledger.due_readings.size();
    $display("meter updates sent: %0d, results checked: %0d, mismatches: %0d",
             ledger.noted, ledger.checked, ledger.errors);
    $display("register writes: %0d over %0d settings, output hold-off of %0d cycles",
             reg_writes, PHASES, HOLD_OFF_CYCLES);
    if (failures == 0) begin
      $display("audio_meter_ballistics_top regression: pass");
    end else begin
      $display("audio_meter_ballistics_top regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/amb_pkg.sv
src/audio_meter_ballistics_top.sv
src/amb_checker.sv
sim/audio_meter_ballistics_top_test.sv
